// ===== hdl/json_string_escaper_top_defines.svh =====
// ---------------------------------------------------------------------------
// json string escaper assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_TOP_DEFINES_SVH
`define JSON_STRING_ESCAPER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define JSE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("json escaper check failed");
// implication checked in the next cycle
`define JSE_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("json escaper check failed");
`else
`define JSE_ASSERT(label, clk, rst, prop)
`define JSE_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// ===== hdl/jse_pkg.sv =====
// ---------------------------------------------------------------------------
// jse_pkg
// shared types, characters and helpers for the json string escaper
// ---------------------------------------------------------------------------
package jse_pkg;

   localparam int STEP_W = 3;   // up to six bytes per input word

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_FF = 8'h0c;
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_DEL = 8'h7f;
   localparam logic [7:0] CH_LOW_B = 8'h62;
   localparam logic [7:0] CH_LOW_F = 8'h66;
   localparam logic [7:0] CH_LOW_N = 8'h6e;
   localparam logic [7:0] CH_LOW_R = 8'h72;
   localparam logic [7:0] CH_LOW_T = 8'h74;
   localparam logic [7:0] CH_LOW_X = 8'h78;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_LOW_A = 8'h61;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_flag;
      logic       last_flag;
      logic       empty_flag;
   } item_type;

   typedef struct packed {
      logic [7:0]        out_byte;
      logic              run_end;
      logic              string_end;
      logic [STEP_W-1:0] count;
   } expand_type;

   // lower-case hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = CH_ZERO + {4'd0, nib};
      end else begin
         r = CH_LOW_A + {4'd0, nib} - 8'd10;
      end
      return r;
   endfunction

endpackage

// ===== hdl/json_string_escaper_top.sv =====
// ---------------------------------------------------------------------------
// json_string_escaper_top
// an input word is loaded into the held-word register, and its bytes then leave
//   through the output register, one result word per cycle while the result side takes
//   them; a word holds the expander until all its bytes (1 to 6) are out, a number set
//   by its escape class and quote markers; the next word may load with its last byte
// reset: synchronous, clears held-word valid, step counter and output valid
// ---------------------------------------------------------------------------
`include "json_string_escaper_top_defines.svh"

module json_string_escaper_top
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_flag,
   input  logic       req_last_flag,
   input  logic       req_empty_flag,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic       rsp_string_end
);

   // held input word and the index of the next byte to emit from it
   item_type          item_ff, item_in;
   logic              item_valid_ff, item_valid_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // output register, parts the result side from the expander
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_run_end_ff, rsp_run_end_in;
   logic              rsp_string_end_ff, rsp_string_end_in;

   expand_type        exp_res;
   logic              out_free;
   logic              emit;
   logic              done;
   logic              req_fire;

   jse_expand u_expand (
      .item (item_ff),
      .step (step_ff),
      .res  (exp_res)
   );

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = item_valid_ff && out_free;
   // last byte of the held word goes out now, so the next word may load
   assign done     = emit && exp_res.run_end;
   assign req_ready = !item_valid_ff || done;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      item_in = item_ff;
      item_valid_in = item_valid_ff;
      step_in = step_ff;
      if (emit) begin
         step_in = step_ff + STEP_W'(1);
      end
      if (done) begin
         item_valid_in = 1'b0;
         step_in = '0;
      end
      if (req_fire) begin
         item_in.data_byte = req_data_byte;
         item_in.first_flag = req_first_flag;
         item_in.last_flag = req_last_flag;
         item_in.empty_flag = req_empty_flag;
         item_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_run_end_in = rsp_run_end_ff;
      rsp_string_end_in = rsp_string_end_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in = exp_res.out_byte;
         rsp_run_end_in = exp_res.run_end;
         rsp_string_end_in = exp_res.string_end;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_run_end_ff <= rsp_run_end_in;
      rsp_string_end_ff <= rsp_string_end_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_end = rsp_run_end_ff;
   assign rsp_string_end = rsp_string_end_ff;

   // step index never runs past the length of the held word
   `JSE_ASSERT(a_step_in_range, clock, reset, !item_valid_ff || step_ff < exp_res.count)
   // a nonzero step only exists while a word is held
   `JSE_ASSERT(a_step_idle, clock, reset, item_valid_ff || step_ff == '0)
   // a closing quote always ends the run of its word
   `JSE_ASSERT(a_close_quote, clock, reset,
      !(rsp_valid_ff && rsp_string_end_ff) || (rsp_run_end_ff && rsp_byte_ff == CH_QUOTE))
   // a taken word is held in the next cycle
   `JSE_ASSERT_NEXT(a_load, clock, reset, req_fire, item_valid_ff && step_ff == '0)

endmodule

// ===== hdl/jse_expand.sv =====
// ---------------------------------------------------------------------------
// jse_expand
// picks one byte of the quoted, escaped form of a held word by step index
// ---------------------------------------------------------------------------
module jse_expand
   import jse_pkg::*;
(
   input  item_type          item,
   input  logic [STEP_W-1:0] step,
   output expand_type        res
);

   logic [7:0]        body [0:3];
   logic [2:0]        body_len;
   logic [7:0]        esc;
   logic              pre;
   logic [STEP_W-1:0] k;
   logic [STEP_W-1:0] n;

   always_comb begin
      case (item.data_byte)
         CH_QUOTE:  esc = CH_QUOTE;
         CH_BSLASH: esc = CH_BSLASH;
         CH_BS:     esc = CH_LOW_B;
         CH_FF:     esc = CH_LOW_F;
         CH_LF:     esc = CH_LOW_N;
         CH_CR:     esc = CH_LOW_R;
         CH_TAB:    esc = CH_LOW_T;
         default:   esc = 8'd0;
      endcase
   end

   always_comb begin
      body[0] = CH_BSLASH;
      body[1] = esc;
      body[2] = hex_char(item.data_byte[7:4]);
      body[3] = hex_char(item.data_byte[3:0]);
      body_len = 3'd2;
      if (esc == 8'd0) begin
         if (item.data_byte inside {[8'h00:8'h1f], CH_DEL}) begin
            body[1] = CH_LOW_X;
            body_len = 3'd4;
         end else begin
            body[0] = item.data_byte;
            body_len = 3'd1;
         end
      end
   end

   always_comb begin
      pre = item.first_flag;
      k = step - {{(STEP_W-1){1'b0}}, pre};
      if (item.empty_flag) begin
         n = STEP_W'(2);
         res.out_byte = CH_QUOTE;
         res.string_end = (step == STEP_W'(1));
      end else begin
         n = {{(STEP_W-1){1'b0}}, pre} + STEP_W'(body_len)
             + {{(STEP_W-1){1'b0}}, item.last_flag};
         res.string_end = 1'b0;
         if (pre && step == '0) begin
            res.out_byte = CH_QUOTE;
         end else if (k < STEP_W'(body_len)) begin
            res.out_byte = body[k[1:0]];
         end else begin
            res.out_byte = CH_QUOTE;
            res.string_end = 1'b1;
         end
      end
      res.run_end = (step == n - STEP_W'(1));
      res.count = n;
   end

endmodule
